@@ sv/gaps_pkg.sv @@
// shared types, constants and helpers for the grid A* path search block
// no dependencies
package gaps_pkg;

  localparam int GRID_ROWS  = 8;
  localparam int GRID_COLS  = 8;
  localparam int OPEN_DEPTH = 64;
  localparam int NCELLS     = 64;
  localparam int CELL_W     = 6;
  localparam int OIDX_W     = $clog2(OPEN_DEPTH);
  localparam int OCNT_W     = $clog2(OPEN_DEPTH + 1);
  localparam int F_W        = 7;
  localparam int G_W        = 6;
  localparam int TRACE_MAX  = NCELLS - 1;

  localparam logic [1:0] ST_PATH = 2'd0;
  localparam logic [1:0] ST_AT_GOAL = 2'd1;
  localparam logic [1:0] ST_NO_PATH = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  localparam logic [1:0] DIR_UP = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;
  localparam logic [1:0] DIR_LEFT = 2'd3;

  typedef logic [CELL_W-1:0] cell_t;

  typedef struct packed {
    logic [F_W-1:0] f;
    logic [G_W-1:0] g;
    cell_t          par;
  } node_t;

  typedef struct packed {
    logic [F_W-1:0] f;
    cell_t          loc;
  } open_t;

  typedef struct packed {
    logic                wall_we;
    cell_t               wall_waddr;
    logic [3:0]          wall_wdata;
    cell_t               wall_raddr;
    logic                node_we;
    cell_t               node_waddr;
    node_t               node_wdata;
    cell_t               node_raddr;
    logic                open_we;
    logic [OIDX_W-1:0]   open_waddr;
    open_t               open_wdata;
    logic [OIDX_W-1:0]   open_raddr;
  } mem_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_POP,
    S_SCAN,
    S_MOVE,
    S_EXPAND,
    S_NB,
    S_NB_CHK,
    S_TR_RD,
    S_TR_EMIT,
    S_FIN
  } state_t;

  function automatic logic [2:0] dist_abs(input logic [2:0] a, input logic [2:0] b);
    dist_abs = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

@@ sv/gaps_mem.sv @@
// wall, node and open list memories, one write and one registered read each
// depends on gaps_pkg
module gaps_mem import gaps_pkg::*; (
  input  logic     clk,
  input  mem_req_t req,
  output logic [3:0] wall_rdata,
  output node_t    node_rdata,
  output open_t    open_rdata
);

  logic [3:0] wall_ram [NCELLS];
  node_t      node_ram [NCELLS];
  open_t      open_ram [OPEN_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wall_we) begin
      wall_ram[req.wall_waddr] <= req.wall_wdata;
    end
    wall_rdata <= wall_ram[req.wall_raddr];
  end

  always_ff @(posedge clk) begin
    if (req.node_we) begin
      node_ram[req.node_waddr] <= req.node_wdata;
    end
    node_rdata <= node_ram[req.node_raddr];
  end

  always_ff @(posedge clk) begin
    if (req.open_we) begin
      open_ram[req.open_waddr] <= req.open_wdata;
    end
    open_rdata <= open_ram[req.open_raddr];
  end

endmodule

@@ sv/grid_astar_path_search.sv @@
// grid A* path search top level: sequencer over wall, node and open list memories
// depends on gaps_pkg and gaps_mem
// load beat: writes one wall entry. search beat: each pop scans the open list for
// the lowest f, then checks neighbors; trace emits one path cell per parent read.
// worst case is near 64 pops of a 64 entry scan. one beat is taken at a time; the
// result register lets a new beat start before the last result is taken. reset
// clears control state only, memories are not cleared
module grid_astar_path_search import gaps_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       req_type,
  input  logic [2:0] cell_row,
  input  logic [2:0] cell_col,
  input  logic       wall_top,
  input  logic       wall_right,
  input  logic       wall_bottom,
  input  logic       wall_left,
  input  logic [2:0] src_row,
  input  logic [2:0] src_col,
  input  logic [2:0] dest_row,
  input  logic [2:0] dest_col,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] status,
  output logic [2:0] step_row,
  output logic [2:0] step_col,
  output logic       last
);

  state_t state, state_next;
  mem_req_t req;
  logic [3:0] wall_rdata;
  node_t node_rdata;
  open_t open_rdata;

  logic [NCELLS-1:0] closed, closed_next;
  logic [NCELLS-1:0] cset, cset_next;
  logic [OCNT_W-1:0] count, count_next;
  logic [OIDX_W-1:0] scan_idx, scan_idx_next;
  logic [OIDX_W-1:0] best, best_next;
  open_t best_ent, best_ent_next;
  cell_t dest, dest_next;
  cell_t cur, cur_next;
  logic [3:0] cur_walls, cur_walls_next;
  logic [G_W-1:0] cur_g, cur_g_next;
  logic [1:0] dir, dir_next;
  cell_t tr_cell, tr_cell_next;
  logic [CELL_W-1:0] tr_k, tr_k_next;
  logic [1:0] fin_status, fin_status_next;
  cell_t fin_cell, fin_cell_next;

  logic out_free;
  logic out_load;
  logic [1:0] o_status;
  cell_t o_cell;
  logic o_last;

  logic [2:0] cr, cc, nr, nc;
  logic nb_ok;
  cell_t nb;
  logic [G_W-1:0] g_new;
  logic [F_W-1:0] f_new;
  logic scan_lt;

  gaps_mem u_mem (
    .clk       (clk),
    .req       (req),
    .wall_rdata(wall_rdata),
    .node_rdata(node_rdata),
    .open_rdata(open_rdata)
  );

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  assign cr = cur[5:3];
  assign cc = cur[2:0];

  always_comb begin
    nr = cr;
    nc = cc;
    nb_ok = 1'b0;
    case (dir)
      DIR_UP: begin
        nr = cr - 3'd1;
        nb_ok = (cr != 3'd0) && !cur_walls[0];
      end
      DIR_RIGHT: begin
        nc = cc + 3'd1;
        nb_ok = ({1'b0, cc} < 4'(GRID_COLS - 1)) && !cur_walls[1];
      end
      DIR_DOWN: begin
        nr = cr + 3'd1;
        nb_ok = ({1'b0, cr} < 4'(GRID_ROWS - 1)) && !cur_walls[2];
      end
      DIR_LEFT: begin
        nc = cc - 3'd1;
        nb_ok = (cc != 3'd0) && !cur_walls[3];
      end
      default: begin
        nb_ok = 1'b0;
      end
    endcase
  end

  assign nb = {nr, nc};
  assign g_new = cur_g + G_W'(1);
  assign f_new = F_W'(g_new) + F_W'(dist_abs(nr, dest[5:3])) + F_W'(dist_abs(nc, dest[2:0]));
  assign scan_lt = open_rdata.f < best_ent.f;

  always_comb begin
    state_next = state;
    closed_next = closed;
    cset_next = cset;
    count_next = count;
    scan_idx_next = scan_idx;
    best_next = best;
    best_ent_next = best_ent;
    dest_next = dest;
    cur_next = cur;
    cur_walls_next = cur_walls;
    cur_g_next = cur_g;
    dir_next = dir;
    tr_cell_next = tr_cell;
    tr_k_next = tr_k;
    fin_status_next = fin_status;
    fin_cell_next = fin_cell;
    out_load = 1'b0;
    o_status = ST_PATH;
    o_cell = tr_cell;
    o_last = 1'b0;

    req = '0;
    req.wall_raddr = cur;
    req.node_raddr = tr_cell;
    req.open_raddr = scan_idx;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (req_type == REQ_LOAD) begin
            req.wall_we = ({1'b0, cell_row} < 4'(GRID_ROWS)) &&
                          ({1'b0, cell_col} < 4'(GRID_COLS));
            req.wall_waddr = {cell_row, cell_col};
            req.wall_wdata = {wall_left, wall_bottom, wall_right, wall_top};
          end else if (({1'b0, src_row} >= 4'(GRID_ROWS)) ||
                       ({1'b0, src_col} >= 4'(GRID_COLS)) ||
                       ({1'b0, dest_row} >= 4'(GRID_ROWS)) ||
                       ({1'b0, dest_col} >= 4'(GRID_COLS))) begin
            fin_status_next = ST_NO_PATH;
            fin_cell_next = '0;
            state_next = S_FIN;
          end else if (src_row == dest_row && src_col == dest_col) begin
            fin_status_next = ST_AT_GOAL;
            fin_cell_next = {src_row, src_col};
            state_next = S_FIN;
          end else begin
            closed_next = '0;
            cset_next = '0;
            cset_next[{src_row, src_col}] = 1'b1;
            dest_next = {dest_row, dest_col};
            req.node_we = 1'b1;
            req.node_waddr = {src_row, src_col};
            req.node_wdata = '{f: '0, g: '0, par: {src_row, src_col}};
            req.open_we = 1'b1;
            req.open_waddr = '0;
            req.open_wdata = '{f: '0, loc: {src_row, src_col}};
            count_next = OCNT_W'(1);
            state_next = S_POP;
          end
        end
      end
      S_POP: begin
        if (count == '0) begin
          fin_status_next = ST_NO_PATH;
          fin_cell_next = '0;
          state_next = S_FIN;
        end else begin
          req.open_raddr = '0;
          scan_idx_next = '0;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_idx == '0 || scan_lt) begin
          best_next = scan_idx;
          best_ent_next = open_rdata;
        end
        if (OCNT_W'(scan_idx) + OCNT_W'(1) < count) begin
          scan_idx_next = scan_idx + OIDX_W'(1);
          req.open_raddr = scan_idx + OIDX_W'(1);
        end else begin
          req.open_raddr = OIDX_W'(count - OCNT_W'(1));
          state_next = S_MOVE;
        end
      end
      S_MOVE: begin
        req.open_we = 1'b1;
        req.open_waddr = best;
        req.open_wdata = open_rdata;
        count_next = count - OCNT_W'(1);
        cur_next = best_ent.loc;
        closed_next[best_ent.loc] = 1'b1;
        req.wall_raddr = best_ent.loc;
        req.node_raddr = best_ent.loc;
        state_next = S_EXPAND;
      end
      S_EXPAND: begin
        cur_walls_next = wall_rdata;
        cur_g_next = node_rdata.g;
        dir_next = DIR_UP;
        state_next = S_NB;
      end
      S_NB: begin
        req.node_raddr = nb;
        if (nb_ok && nb == dest) begin
          req.node_we = 1'b1;
          req.node_waddr = dest;
          req.node_wdata = '{f: '0, g: '0, par: cur};
          tr_cell_next = dest;
          tr_k_next = '0;
          state_next = S_TR_RD;
        end else if (nb_ok && !closed[nb]) begin
          state_next = S_NB_CHK;
        end else if (dir == DIR_LEFT) begin
          state_next = S_POP;
        end else begin
          dir_next = dir + 2'd1;
        end
      end
      S_NB_CHK: begin
        state_next = (dir == DIR_LEFT) ? S_POP : S_NB;
        dir_next = dir + 2'd1;
        if (!cset[nb] || node_rdata.f > f_new) begin
          if (count >= OCNT_W'(OPEN_DEPTH)) begin
            fin_status_next = ST_OVERFLOW;
            fin_cell_next = '0;
            state_next = S_FIN;
          end else begin
            req.open_we = 1'b1;
            req.open_waddr = OIDX_W'(count);
            req.open_wdata = '{f: f_new, loc: nb};
            count_next = count + OCNT_W'(1);
            cset_next[nb] = 1'b1;
            req.node_we = 1'b1;
            req.node_waddr = nb;
            req.node_wdata = '{f: f_new, g: g_new, par: cur};
          end
        end
      end
      S_TR_RD: begin
        state_next = S_TR_EMIT;
      end
      S_TR_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          o_status = ST_PATH;
          o_cell = tr_cell;
          if (tr_k < CELL_W'(TRACE_MAX) && node_rdata.par != tr_cell) begin
            o_last = 1'b0;
            tr_cell_next = node_rdata.par;
            tr_k_next = tr_k + CELL_W'(1);
            state_next = S_TR_RD;
          end else begin
            o_last = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_load = 1'b1;
          o_status = fin_status;
          o_cell = fin_cell;
          o_last = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      closed <= '0;
      cset <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      closed <= closed_next;
      cset <= cset_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_idx <= scan_idx_next;
    best <= best_next;
    best_ent <= best_ent_next;
    dest <= dest_next;
    cur <= cur_next;
    cur_walls <= cur_walls_next;
    cur_g <= cur_g_next;
    dir <= dir_next;
    tr_cell <= tr_cell_next;
    tr_k <= tr_k_next;
    fin_status <= fin_status_next;
    fin_cell <= fin_cell_next;
    if (out_load) begin
      status <= o_status;
      step_row <= o_cell[5:3];
      step_col <= o_cell[2:0];
      last <= o_last;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= OCNT_W'(OPEN_DEPTH))
    else $error("open list count beyond depth");

  a_move_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == S_MOVE |-> count != '0)
    else $error("pop from empty open list");

  a_load_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> out_free)
    else $error("result register overwritten before taken");

  a_pop_closes: assert property (@(posedge clk) disable iff (rst)
    state == S_MOVE |=> closed[cur])
    else $error("popped cell not closed");

endmodule

@@ bench/tb.sv @@
// testbench for grid_astar_path_search: loads mazes, runs searches, checks every path beat
// against an in-bench A* predictor; depends on gaps_pkg and the block's rtl
module tb import gaps_pkg::*;;

  typedef struct {
    logic       kind;
    logic [2:0] crow, ccol;
    logic [3:0] walls;
    logic [2:0] srow, scol, drow, dcol;
    bit         typed;
    logic [1:0] t_status;
    logic [2:0] t_row, t_col;
  } req_row_t;

  typedef struct {
    logic [1:0] status;
    logic [2:0] row, col;
    logic       last;
  } step_t;

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_ready;
  logic req_type = 0;
  logic [2:0] cell_row = 0, cell_col = 0, src_row = 0, src_col = 0, dest_row = 0, dest_col = 0;
  logic wall_top = 0, wall_right = 0, wall_bottom = 0, wall_left = 0;
  logic out_valid, out_ready = 0;
  logic [1:0] status;
  logic [2:0] step_row, step_col;
  logic last;

  logic [3:0] maze_walls [NCELLS];
  step_t path_q[$];
  int errors = 0, searches = 0, loads = 0, steps_seen = 0, idle_cycles = 0;
  int max_gap = 18;
  bit hold_req = 0;
  int status_seen [4];

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  grid_astar_path_search i_dut (.*);

  function automatic void expect_path(input logic [2:0] sr, sc, dr, dc);
    int row_off [4] = '{-1, 0, 1, 0};
    int col_off [4] = '{0, 1, 0, -1};
    bit closed [NCELLS];
    bit known [NCELLS];
    int fcost [NCELLS];
    int gcost [NCELLS];
    int par [NCELLS];
    int open_f [OPEN_DEPTH];
    int open_c [OPEN_DEPTH];
    int cnt, best, cur, r, c, nr, nc, nb, g, f, src, dst, k, walk;
    step_t s;
    s.status = ST_PATH; s.row = 0; s.col = 0; s.last = 1;
    if (sr == dr && sc == dc) begin
      s.status = ST_AT_GOAL; s.row = sr; s.col = sc;
      path_q.push_back(s);
      return;
    end
    foreach (closed[i]) begin
      closed[i] = 0; known[i] = 0; fcost[i] = 0; gcost[i] = 0; par[i] = i;
    end
    src = sr * 8 + sc;
    dst = dr * 8 + dc;
    known[src] = 1;
    open_f[0] = 0; open_c[0] = src; cnt = 1;
    while (cnt > 0) begin
      best = 0;
      for (int j = 1; j < cnt; j++)
        if (open_f[j] < open_f[best]) best = j;
      cur = open_c[best];
      open_f[best] = open_f[cnt-1]; open_c[best] = open_c[cnt-1];
      cnt--;
      closed[cur] = 1;
      r = cur / 8; c = cur % 8;
      for (int m = 0; m < 4; m++) begin
        nr = r + row_off[m]; nc = c + col_off[m];
        if (nr < 0 || nr > 7 || nc < 0 || nc > 7 || maze_walls[cur][m]) continue;
        nb = nr * 8 + nc;
        if (nb == dst) begin
          par[nb] = cur;
          walk = dst; k = 0;
          while (k < NCELLS - 1 && par[walk] != walk) begin
            s.status = ST_PATH; s.row = 3'(walk / 8); s.col = 3'(walk % 8); s.last = 0;
            path_q.push_back(s);
            walk = par[walk]; k++;
          end
          s.status = ST_PATH; s.row = 3'(walk / 8); s.col = 3'(walk % 8); s.last = 1;
          path_q.push_back(s);
          return;
        end
        if (closed[nb]) continue;
        g = (gcost[cur] + 1) & 63;
        f = (g + (nr > dr ? nr - dr : dr - nr) + (nc > dc ? nc - dc : dc - nc)) & 127;
        if (!known[nb] || fcost[nb] > f) begin
          if (cnt >= OPEN_DEPTH) begin
            s.status = ST_OVERFLOW; s.row = 0; s.col = 0; s.last = 1;
            path_q.push_back(s);
            return;
          end
          open_f[cnt] = f; open_c[cnt] = nb; cnt++;
          known[nb] = 1; fcost[nb] = f; gcost[nb] = g; par[nb] = cur;
        end
      end
    end
    s.status = ST_NO_PATH; s.row = 0; s.col = 0; s.last = 1;
    path_q.push_back(s);
  endfunction

  task automatic send(input req_row_t q);
    int gap;
    in_valid <= 1;
    req_type <= q.kind;
    cell_row <= q.crow; cell_col <= q.ccol;
    {wall_left, wall_bottom, wall_right, wall_top} <= q.walls;
    src_row <= q.srow; src_col <= q.scol; dest_row <= q.drow; dest_col <= q.dcol;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (q.kind == REQ_LOAD) begin
      maze_walls[q.crow * 8 + q.ccol] = q.walls;
      loads++;
    end else begin
      searches++;
      if (q.typed)
        path_q.push_back('{q.t_status, q.t_row, q.t_col, 1'b1});
      else
        expect_path(q.srow, q.scol, q.drow, q.dcol);
    end
    gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic req_row_t load_row(input int idx, input logic [3:0] w);
    req_row_t q;
    q = '{REQ_LOAD, 3'(idx / 8), 3'(idx % 8), w, 0, 0, 0, 0, 0, ST_PATH, 0, 0};
    return q;
  endfunction

  function automatic req_row_t search_row(input logic [2:0] a, b, c, d);
    req_row_t q;
    q = '{REQ_SEARCH, 3'($urandom), 3'($urandom), 4'($urandom), a, b, c, d, 0, ST_PATH, 0, 0};
    return q;
  endfunction

  task automatic drain();
    in_valid <= 0;
    while (path_q.size() > 0) @(posedge clk);
  endtask

  task automatic random_items(input int n);
    req_row_t q;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 4)
        q = load_row($urandom_range(0, 63), ($urandom_range(0, 2) == 0) ? 4'($urandom) : 4'h0
                     | ($urandom_range(0, 3) == 0 ? 4'(1 << $urandom_range(0, 3)) : 4'h0));
      else
        q = search_row(3'($urandom), 3'($urandom), 3'($urandom), 3'($urandom));
      send(q);
    end
  endtask

  // receiver side
  initial begin
    int n;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        out_ready <= 0;
        repeat (800) @(posedge clk);
        hold_req = 0;
      end else begin
        n = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
        if (n > 0) begin
          out_ready <= 0;
          repeat (n) @(posedge clk);
        end
      end
      out_ready <= 1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (path_q.size() == 0) begin
        $display("%0t: unexpected beat status %0d step %0d,%0d last %0d",
                 $time, status, step_row, step_col, last);
        errors++;
      end else begin
        step_t e;
        e = path_q.pop_front();
        if (e.status !== status || e.row !== step_row || e.col !== step_col
            || e.last !== last) begin
          $display("%0t: expected status %0d step %0d,%0d last %0d, got %0d %0d,%0d %0d",
                   $time, e.status, e.row, e.col, e.last, status, step_row, step_col, last);
          errors++;
        end
        status_seen[status]++;
        steps_seen++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= 60000) begin
      $display("%0t: no progress, gave up", $time);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    req_row_t directed [$];
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // open maze, then a walled corner and an extreme edge cell
    max_gap = 0;
    for (int i = 0; i < NCELLS; i++) send(load_row(i, 4'h0));
    max_gap = 18;
    directed.push_back('{REQ_SEARCH, 0, 0, 0, 0, 0, 0, 0, 1, ST_AT_GOAL, 0, 0});
    directed.push_back('{REQ_SEARCH, 7, 7, 4'hf, 7, 7, 7, 7, 1, ST_AT_GOAL, 7, 7});
    directed.push_back('{REQ_SEARCH, 0, 0, 0, 3, 5, 3, 5, 1, ST_AT_GOAL, 3, 5});
    directed.push_back(search_row(0, 0, 0, 1));
    directed.push_back(search_row(0, 0, 7, 7));
    directed.push_back(search_row(7, 7, 0, 0));
    directed.push_back(search_row(7, 0, 0, 7));
    directed.push_back(search_row(3, 4, 3, 3));
    directed.push_back(load_row(0, 4'hf));
    directed.push_back('{REQ_SEARCH, 0, 0, 0, 0, 0, 7, 7, 1, ST_NO_PATH, 0, 0});
    directed.push_back(search_row(7, 7, 0, 0));
    directed.push_back(load_row(63, 4'hf));
    directed.push_back(search_row(7, 6, 7, 7));
    directed.push_back(search_row(6, 7, 7, 7));
    directed.push_back(load_row(0, 4'h5));
    directed.push_back(search_row(0, 0, 0, 7));
    directed.push_back(load_row(0, 4'ha));
    directed.push_back(search_row(0, 0, 7, 0));
    directed.push_back(load_row(63, 4'h0));
    directed.push_back(load_row(0, 4'h0));
    foreach (directed[i]) send(directed[i]);
    drain();

    // mixed wall loads and searches
    random_items(20);
    drain();

    // long receiver stall with back-to-back beats
    max_gap = 0;
    hold_req = 1;
    random_items(12);
    drain();

    // no idling on either side, then random idle gaps on both sides again
    random_items(12);
    max_gap = 18;
    random_items(12);
    drain();

    repeat (200) @(posedge clk);
    $display("covered %0d wall loads, %0d searches, %0d path beats", loads, searches, steps_seen);
    $display("status counts: path %0d, at goal %0d, no path %0d, overflow %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (errors == 0 && path_q.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/gaps_pkg.sv
sv/gaps_mem.sv
sv/grid_astar_path_search.sv
bench/tb.sv
